>>> rtl/core/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

  // Heap geometry
  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int ADDR_W       = $clog2(HEAP_BYTES);   // byte offset into the heap
  localparam int POS_W        = ADDR_W + 1;           // walk position, may reach HEAP_BYTES
  localparam int SIZE_W       = 12;                   // chunk data size field
  localparam int OFS_W        = 12;                   // offset fields on the channels

  localparam logic [POS_W-1:0]  HDR_POS     = POS_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HDR_SIZE    = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] RESET_SIZE  = SIZE_W'(HEAP_BYTES - HEADER_BYTES);

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_NOFIT = 1'b1;

  // One header entry
  typedef struct packed {
    logic              busy;
    logic [SIZE_W-1:0] size;
  } header_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_SPLIT,
    S_F_RD,
    S_F_WR,
    S_M_RD,
    S_M_CHK,
    S_M_NRD,
    S_M_NCHK,
    S_M_WB,
    S_DONE
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_NOFIT,
    OP_A_READ,
    OP_A_CHECK,
    OP_A_SPLIT,
    OP_F_READ,
    OP_F_WRITE,
    OP_M_READ,
    OP_M_CHECK,
    OP_M_NREAD,
    OP_M_NCHECK,
    OP_M_WB,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;    // latched command is a free
    logic head_ok;    // free offset is at least one header
    logic at_end;     // walk position reached the end of the heap
    logic nx_end;     // merge neighbor is at or past the end of the heap
    logic e_busy;     // read entry is busy
    logic fit;        // read entry is free and large enough
    logic split;      // remainder can hold a header and starts in the heap
    logic slot_free;  // output register can take a result
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ffha_if.sv
// Handshake channels of the allocator: request and response.
// Depends on ffha_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ffha_req_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [ffha_pkg::OFS_W-1:0] request_size;
  logic [ffha_pkg::OFS_W-1:0] free_offset;

  modport source (output valid, command, request_size, free_offset, input ready);
  modport sink   (input valid, command, request_size, free_offset, output ready);
endinterface

interface ffha_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ffha_pkg::OFS_W-1:0] data_offset;
  logic                      status;

  modport source (output valid, data_offset, status, input ready);
  modport sink   (input valid, data_offset, status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ffha_dp.sv
// Allocator datapath: header store memory, walk registers and result register.
// Depends on ffha_pkg; driven by ffha_ctrl through dp_cmd_t / dp_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module ffha_dp (
  input  wire                         clk,
  input  wire                         rst,
  input  ffha_pkg::dp_cmd_t           cmd,
  output ffha_pkg::dp_stat_t          stat,
  input  wire                         command,
  input  wire  [ffha_pkg::OFS_W-1:0]  request_size,
  input  wire  [ffha_pkg::OFS_W-1:0]  free_offset,
  output logic                        rsp_valid,
  input  wire                         rsp_ready,
  output logic [ffha_pkg::OFS_W-1:0]  data_offset,
  output logic                        status
);
  import ffha_pkg::*;

  // Header store
  header_t            mem [HEAP_BYTES];
  header_t            mem_q;
  logic [ADDR_W-1:0]  rd_addr_q;
  logic               e0_valid;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  header_t            wr_data;

  // Walk and request registers
  logic               cmd_r;
  logic [SIZE_W-1:0]  want;
  logic [OFS_W-1:0]   given;
  logic [POS_W-1:0]   at;
  logic [POS_W-1:0]   nx;
  logic [SIZE_W-1:0]  cur_size;
  logic [OFS_W-1:0]   res_offset;
  logic               res_status;

  header_t            entry;
  logic [SIZE_W-1:0]  spare;
  logic [POS_W-1:0]   at_next;
  logic [POS_W-1:0]   at_merged;
  logic [POS_W-1:0]   rest;
  logic [SIZE_W-1:0]  merged_size;
  logic [POS_W-1:0]   merged_nx;
  logic [ADDR_W-1:0]  head;

  // Entry at offset 0 reads as the initial whole-heap chunk until first written
  always_comb begin
    if (rd_addr_q == '0 && !e0_valid) begin
      entry.busy = 1'b0;
      entry.size = RESET_SIZE;
    end else begin
      entry = mem_q;
    end
  end

  // Arithmetic on the read entry
  assign spare       = entry.size - want;
  assign at_next     = at + HDR_POS + {1'b0, entry.size};
  assign at_merged   = at + HDR_POS + {1'b0, cur_size};
  assign rest        = at + HDR_POS + {1'b0, want};
  assign merged_size = cur_size + entry.size + HDR_SIZE;
  assign merged_nx   = at + HDR_POS + {1'b0, merged_size};
  assign head        = ADDR_W'(given - HDR_SIZE);

  // Status to the controller
  always_comb begin
    stat.is_free   = (cmd_r == CMD_FREE);
    stat.head_ok   = (given >= HDR_SIZE);
    stat.at_end    = at[POS_W-1];
    stat.nx_end    = nx[POS_W-1];
    stat.e_busy    = entry.busy;
    stat.fit       = !entry.busy && (entry.size >= want);
    stat.split     = (spare >= HDR_SIZE) && !rest[POS_W-1];
    stat.slot_free = !rsp_valid || rsp_ready;
  end

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = at[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = at[ADDR_W-1:0];
    wr_data = entry;
    unique case (cmd.op)
      OP_A_READ, OP_M_READ: begin
        rd_en = 1'b1;
      end
      OP_F_READ: begin
        rd_en   = 1'b1;
        rd_addr = head;
      end
      OP_M_NREAD: begin
        rd_en   = 1'b1;
        rd_addr = nx[ADDR_W-1:0];
      end
      OP_A_CHECK: begin
        wr_en        = stat.fit;
        wr_data.busy = 1'b1;
        wr_data.size = stat.split ? want : entry.size;
      end
      OP_A_SPLIT: begin
        wr_en        = 1'b1;
        wr_addr      = rest[ADDR_W-1:0];
        wr_data.busy = 1'b0;
        wr_data.size = cur_size;
      end
      OP_F_WRITE: begin
        wr_en        = 1'b1;
        wr_addr      = head;
        wr_data.busy = 1'b0;
        wr_data.size = entry.size;
      end
      OP_M_WB: begin
        wr_en        = 1'b1;
        wr_data.busy = 1'b0;
        wr_data.size = cur_size;
      end
      default: begin
      end
    endcase
  end

  // Memory array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Valid mark for offset 0
  always_ff @(posedge clk) begin
    if (rst) begin
      e0_valid <= 1'b0;
    end else if (wr_en && wr_addr == '0) begin
      e0_valid <= 1'b1;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        cmd_r      <= command;
        want       <= request_size;
        given      <= free_offset;
        at         <= '0;
        res_offset <= '0;
        res_status <= ST_DONE;
      end
      OP_NOFIT: begin
        res_offset <= '0;
        res_status <= ST_NOFIT;
      end
      OP_A_CHECK: begin
        if (stat.fit) begin
          cur_size   <= spare - HDR_SIZE;
          res_offset <= OFS_W'(at + HDR_POS);
          res_status <= ST_DONE;
        end else begin
          at <= at_next;
        end
      end
      OP_F_WRITE: begin
        at <= '0;
      end
      OP_M_CHECK: begin
        cur_size <= entry.size;
        if (entry.busy) begin
          at <= at_next;
        end else begin
          nx <= at_next;
        end
      end
      OP_M_NCHECK: begin
        if (!entry.busy) begin
          cur_size <= merged_size;
          nx       <= merged_nx;
        end
      end
      OP_M_WB: begin
        at <= at_merged;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.op == OP_RESULT) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESULT) begin
      data_offset <= res_offset;
      status      <= res_status;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ffha_ctrl.sv
// Allocator controller: sequences the chunk walks for alloc, free and merge.
// Depends on ffha_pkg; drives ffha_dp through dp_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  input  wire                 req_command,
  output logic                req_ready,
  output ffha_pkg::dp_cmd_t   cmd,
  input  ffha_pkg::dp_stat_t  stat
);
  import ffha_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req_command == CMD_FREE) ? S_F_RD : S_A_RD;
        end
      end
      S_A_RD:    state_next = stat.at_end ? S_DONE : S_A_CHK;
      S_A_CHK: begin
        if (stat.fit) begin
          state_next = stat.split ? S_A_SPLIT : S_DONE;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_A_SPLIT: state_next = S_DONE;
      S_F_RD:    state_next = stat.head_ok ? S_F_WR : S_DONE;
      S_F_WR:    state_next = S_M_RD;
      S_M_RD:    state_next = stat.at_end ? S_DONE : S_M_CHK;
      S_M_CHK:   state_next = stat.e_busy ? S_M_RD : S_M_NRD;
      S_M_NRD:   state_next = stat.nx_end ? S_M_WB : S_M_NCHK;
      S_M_NCHK:  state_next = stat.e_busy ? S_M_WB : S_M_NRD;
      S_M_WB:    state_next = S_M_RD;
      S_DONE:    state_next = stat.slot_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready = 1'b0;
    cmd.op    = OP_NONE;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      S_A_RD:    cmd.op = stat.at_end ? OP_NOFIT : OP_A_READ;
      S_A_CHK:   cmd.op = OP_A_CHECK;
      S_A_SPLIT: cmd.op = OP_A_SPLIT;
      S_F_RD:    cmd.op = stat.head_ok ? OP_F_READ : OP_NONE;
      S_F_WR:    cmd.op = OP_F_WRITE;
      S_M_RD:    cmd.op = stat.at_end ? OP_NONE : OP_M_READ;
      S_M_CHK:   cmd.op = OP_M_CHECK;
      S_M_NRD:   cmd.op = stat.nx_end ? OP_NONE : OP_M_NREAD;
      S_M_NCHK:  cmd.op = OP_M_NCHECK;
      S_M_WB:    cmd.op = OP_M_WB;
      S_DONE:    cmd.op = stat.slot_free ? OP_RESULT : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/first_fit_heap_allocator_core.sv
// First-fit heap allocator with coalescing. A 4096-byte heap is kept as an
// implicit list of chunks, each with a 16-byte header (data size, busy mark)
// held in a 4096 x 13 header store with one registered read port. One item is
// worked at a time. An alloc walks chunks from offset 0, reading each header
// and then checking it, and splits the chosen chunk when the rest can hold a
// header and starts inside the heap. A free loads the request, reads and
// rewrites the header, then (unless the offset is below one header, which
// skips the merge) runs a merge walk over the whole heap that folds each run
// of free chunks into its first chunk, with a neighbor check and write-back
// per free run, and stops at the end. The result waits in an output register,
// so the next item is taken while it is still pending. No clearing pass is
// needed after reset.
// Depends on ffha_pkg, ffha_if, ffha_ctrl and ffha_dp.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator_core (
  input wire            clk,
  input wire            rst,
  ffha_req_if.sink      req,
  ffha_rsp_if.source    rsp
);
  import ffha_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  ffha_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.command),
    .req_ready   (req.ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  // Header store and walk datapath
  ffha_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (req.command),
    .request_size (req.request_size),
    .free_offset  (req.free_offset),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .data_offset  (rsp.data_offset),
    .status       (rsp.status)
  );

endmodule

`default_nettype wire

>>> tb/tb_first_fit_heap_allocator_core.sv
// Self-checking testbench for first_fit_heap_allocator_core: directed table then
// random alloc/free traffic; replies match typed rows or a first-fit heap predictor.
// Depends on ffha_pkg, ffha_if and first_fit_heap_allocator_core.
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_core;
  import ffha_pkg::*;

  localparam int IDLE_PCT     = 26;
  localparam int RANDOM_ITEMS = 950;
  localparam int LIVE_CAP     = 48;

  // One reply of the block
  typedef struct packed {
    logic [OFS_W-1:0] data_offset;
    logic             status;
  } heap_reply_t;

  // One row of the directed table; typed marks a reply written in by hand
  typedef struct packed {
    logic             command;
    logic [OFS_W-1:0] request_size;
    logic [OFS_W-1:0] free_offset;
    logic             typed;
    logic [OFS_W-1:0] exp_offset;
    logic             exp_status;
  } script_row_t;

  logic clk;
  logic rst;

  ffha_req_if req_ch ();
  ffha_rsp_if rsp_ch ();

  first_fit_heap_allocator_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Mirror of the header store and bookkeeping
  header_t          heap_heads [HEAP_BYTES];
  heap_reply_t      replies_due [$];
  logic [OFS_W-1:0] live_offsets [$];
  script_row_t      script [$];
  int               mismatches;
  int               replies_seen;
  int               random_sent;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Run limit
  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Heap predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned chunk_after(int unsigned at);
    return at + HEADER_BYTES + heap_heads[at].size;
  endfunction

  function automatic void clear_heap();
    for (int i = 0; i < HEAP_BYTES; i++) heap_heads[i] = '0;
    heap_heads[0].busy = 1'b0;
    heap_heads[0].size = RESET_SIZE;
  endfunction

  // Fold each run of adjacent free chunks into its first chunk
  function automatic void coalesce_free_runs();
    int unsigned at;
    int unsigned nx;
    at = 0;
    while (at < HEAP_BYTES) begin
      if (!heap_heads[at].busy) begin
        nx = chunk_after(at);
        while (nx < HEAP_BYTES && !heap_heads[nx].busy) begin
          heap_heads[at].size = heap_heads[at].size + heap_heads[nx].size + HDR_SIZE;
          nx = chunk_after(at);
        end
      end
      at = chunk_after(at);
    end
  endfunction

  function automatic heap_reply_t predict_command(logic cmd, logic [OFS_W-1:0] want,
                                                  logic [OFS_W-1:0] given);
    heap_reply_t reply;
    int unsigned at;
    int unsigned spare;
    int unsigned rest;
    reply.data_offset = '0;
    reply.status      = ST_DONE;
    if (cmd == CMD_ALLOC) begin
      at = 0;
      while (at < HEAP_BYTES) begin
        if (!heap_heads[at].busy && heap_heads[at].size >= want) begin
          spare = heap_heads[at].size - want;
          // split only when the rest can hold a header
          if (spare >= HEADER_BYTES) begin
            rest = at + HEADER_BYTES + want;
            if (rest < HEAP_BYTES) begin
              heap_heads[rest].size = SIZE_W'(spare - HEADER_BYTES);
              heap_heads[rest].busy = 1'b0;
              heap_heads[at].size   = want;
            end
          end
          heap_heads[at].busy = 1'b1;
          reply.data_offset = OFS_W'(at + HEADER_BYTES);
          live_offsets.push_back(reply.data_offset);
          return reply;
        end
        at = chunk_after(at);
      end
      reply.status = ST_NOFIT;
      return reply;
    end
    // free: offsets below one header are dropped
    if (given >= HEADER_BYTES) begin
      heap_heads[given - HEADER_BYTES].busy = 1'b0;
      coalesce_free_runs();
    end
    return reply;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  task automatic add_row(logic cmd, int size, int ofs, logic typed, int exp_ofs,
                         logic exp_st);
    script_row_t r;
    r.command      = cmd;
    r.request_size = OFS_W'(size);
    r.free_offset  = OFS_W'(ofs);
    r.typed        = typed;
    r.exp_offset   = OFS_W'(exp_ofs);
    r.exp_status   = exp_st;
    script.push_back(r);
  endtask

  task automatic build_script();
    add_row(CMD_ALLOC, 4080, 0, 1'b1, 16, ST_DONE);     // whole heap, exact fit
    add_row(CMD_ALLOC, 0, 0, 1'b1, 0, ST_NOFIT);        // heap full
    add_row(CMD_FREE, 0, 16, 1'b1, 0, ST_DONE);
    add_row(CMD_ALLOC, 0, 0, 1'b1, 16, ST_DONE);        // zero-byte chunk, split
    add_row(CMD_ALLOC, 4065, 0, 1'b1, 0, ST_NOFIT);     // one byte too many
    add_row(CMD_ALLOC, 4050, 0, 1'b1, 32, ST_DONE);     // near fit, no split
    add_row(CMD_FREE, 0, 32, 1'b1, 0, ST_DONE);
    add_row(CMD_FREE, 0, 0, 1'b1, 0, ST_DONE);          // below a header: dropped
    add_row(CMD_FREE, 0, 15, 1'b1, 0, ST_DONE);
    add_row(CMD_ALLOC, 100, 0, 1'b1, 32, ST_DONE);
    add_row(CMD_ALLOC, 4080, 0, 1'b1, 0, ST_NOFIT);
    add_row(CMD_ALLOC, 1, 0, 1'b0, 0, ST_DONE);
    add_row(CMD_FREE, 0, 4095, 1'b1, 0, ST_DONE);       // not a data start
    add_row(CMD_FREE, 0, 40, 1'b1, 0, ST_DONE);         // inside a busy chunk
    add_row(CMD_FREE, 0, 16, 1'b1, 0, ST_DONE);
    add_row(CMD_ALLOC, 0, 0, 1'b1, 16, ST_DONE);        // reuse the zero-size chunk
    add_row(CMD_FREE, 0, 32, 1'b0, 0, ST_DONE);
    add_row(CMD_FREE, 0, 148, 1'b0, 0, ST_DONE);        // merges three chunks
    add_row(CMD_ALLOC, 4064, 0, 1'b0, 0, ST_DONE);
    add_row(CMD_FREE, 0, 16, 1'b0, 0, ST_DONE);
    add_row(CMD_FREE, 0, 32, 1'b0, 0, ST_DONE);         // back to one free chunk
    add_row(CMD_ALLOC, 4080, 0, 1'b1, 16, ST_DONE);
    add_row(CMD_FREE, 0, 16, 1'b1, 0, ST_DONE);
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic request_gap(bit quiet);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Offer one item, wait for it to be taken, then predict its reply
  task automatic issue_command(logic cmd, logic [OFS_W-1:0] want, logic [OFS_W-1:0] given,
                               output heap_reply_t reply);
    req_ch.valid        <= 1'b1;
    req_ch.command      <= cmd;
    req_ch.request_size <= want;
    req_ch.free_offset  <= given;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    reply = predict_command(cmd, want, given);
  endtask

  initial begin : request_side
    heap_reply_t      reply;
    script_row_t      r;
    logic             cmd;
    logic [OFS_W-1:0] want;
    logic [OFS_W-1:0] given;
    int               roll;
    int               pick;

    req_ch.valid        <= 1'b0;
    req_ch.command      <= CMD_ALLOC;
    req_ch.request_size <= '0;
    req_ch.free_offset  <= '0;
    mismatches  = 0;
    random_sent = 0;
    clear_heap();
    build_script();
    wait (rst === 1'b0);
    @(posedge clk);

    // directed rows
    foreach (script[i]) begin
      r = script[i];
      request_gap(1'b0);
      issue_command(r.command, r.request_size, r.free_offset, reply);
      if (r.typed) begin
        reply.data_offset = r.exp_offset;
        reply.status      = r.exp_status;
      end
      replies_due.push_back(reply);
    end
    live_offsets.delete();

    // random traffic: mostly frees of live chunks and allocs, some stray frees
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll  = $urandom_range(99);
      want  = '0;
      given = '0;
      if (live_offsets.size() == 0 || (roll < 48 && live_offsets.size() < LIVE_CAP)) begin
        cmd  = CMD_ALLOC;
        roll = $urandom_range(99);
        if (roll < 70)      want = OFS_W'($urandom_range(127));
        else if (roll < 92) want = OFS_W'($urandom_range(1023, 128));
        else                want = OFS_W'($urandom_range(4080, 1024));
      end else if (roll < 92) begin
        cmd   = CMD_FREE;
        pick  = $urandom_range(live_offsets.size() - 1);
        given = live_offsets[pick];
        live_offsets.delete(pick);
      end else begin
        cmd   = CMD_FREE;
        given = OFS_W'($urandom_range(4095));
      end
      request_gap(n >= 350 && n < 600);
      issue_command(cmd, want, given, reply);
      replies_due.push_back(reply);
      random_sent++;
    end
    req_ch.valid <= 1'b0;

    // drain, then let the block settle
    while (replies_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------
  task automatic check_reply(logic [OFS_W-1:0] data_offset, logic status);
    heap_reply_t want;
    if (replies_due.size() == 0) begin
      $error("unexpected reply: data_offset %0d status %0d", data_offset, status);
      mismatches++;
      return;
    end
    want = replies_due.pop_front();
    if (data_offset !== want.data_offset) begin
      $error("data_offset: expected %0d, got %0d", want.data_offset, data_offset);
      mismatches++;
    end
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      mismatches++;
    end
  endtask

  initial begin : response_side
    int hold_left;
    bit held;
    hold_left    = 0;
    held         = 1'b0;
    replies_seen = 0;
    rsp_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_reply(rsp_ch.data_offset, rsp_ch.status);
        replies_seen++;
      end
      // one long back-pressure stretch so the block fills and stalls its input
      if (!held && replies_seen == 150) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= (replies_seen >= 380 && replies_seen < 620) ||
                        ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

endmodule
